### rtl/arp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_pkg
// Shared constants, types and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package arp_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int STAMP_W = 32;
    localparam int AGE_W   = 16;
    localparam int ADDR_W  = 4;

    localparam logic [1:0] CMD_LOOKUP  = 2'd0;
    localparam logic [1:0] CMD_REQUEST = 2'd1;
    localparam logic [1:0] CMD_REPLY   = 2'd2;
    localparam logic [1:0] CMD_NONE    = 2'd3;

    localparam logic [ADDR_W-1:0] REG_ENABLE  = 4'h0;
    localparam logic [ADDR_W-1:0] REG_OWN_IP  = 4'h4;
    localparam logic [ADDR_W-1:0] REG_MAX_AGE = 4'h8;

    localparam logic [AGE_W-1:0] MAX_AGE_RST = 16'd300;
    localparam logic [MAC_W-1:0] MAC_BCAST   = {MAC_W{1'b1}};

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // capture input transaction
        logic age;      // advance tick, wrap, expire
        logic search;   // resolve lookup hit/refresh
        logic learn;    // write learned mapping
    } arp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_lookup;
        logic do_learn;
    } arp_sts_t;

endpackage

### rtl/arp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_datapath
// Cache table, tick counter, aging, search, victim select and result regs.
// ----------------------------------------------------------------------------
module arp_datapath (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  arp_pkg::arp_cmd_t          cmd_i,
    output arp_pkg::arp_sts_t          sts_o,
    input  logic                       enable_i,
    input  logic [31:0]                own_ip_i,
    input  logic [15:0]                max_age_i,
    input  logic [1:0]                 s_cmd,
    input  logic [31:0]                s_address,
    input  logic [47:0]                s_hw_addr,
    input  logic [31:0]                s_target_addr,
    output logic                       res_ok_o,
    output logic [47:0]                res_mac_o,
    output logic                       res_reply_o
);
    import arp_pkg::*;

    logic [ENTRIES-1:0] valid_reg;
    logic [IP_W-1:0]    ip_reg    [ENTRIES];
    logic [MAC_W-1:0]   mac_reg   [ENTRIES];
    logic [STAMP_W-1:0] stamp_reg [ENTRIES];
    logic [STAMP_W-1:0] tick_reg;

    logic [1:0]         op_reg;
    logic [IP_W-1:0]    addr_reg;
    logic [MAC_W-1:0]   hw_reg;

    logic               ok_reg;
    logic [MAC_W-1:0]   fmac_reg;
    logic               reply_reg;

    // Learn decision registered at load time
    logic learn_reg;

    // Per-entry match against captured address
    logic [ENTRIES-1:0] match;
    logic               hit;
    logic [IDX_W-1:0]   hit_idx;
    logic               has_free;
    logic [IDX_W-1:0]   free_idx;
    logic [IDX_W-1:0]   old_idx;
    logic [IDX_W-1:0]   wr_idx;

    // Oldest-stamp select as a balanced tree; lower index wins on ties
    logic [STAMP_W-1:0] age_stamp [2*ENTRIES-1];
    logic [IDX_W-1:0]   age_idx   [2*ENTRIES-1];

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            age_stamp[ENTRIES-1+i] = stamp_reg[i];
            age_idx[ENTRIES-1+i]   = IDX_W'(i);
        end
        for (int n = ENTRIES-2; n >= 0; n--) begin
            if (age_stamp[2*n+2] < age_stamp[2*n+1]) begin
                age_stamp[n] = age_stamp[2*n+2];
                age_idx[n]   = age_idx[2*n+2];
            end else begin
                age_stamp[n] = age_stamp[2*n+1];
                age_idx[n]   = age_idx[2*n+1];
            end
        end
    end

    assign old_idx = age_idx[0];

    always_comb begin
        hit = 1'b0; hit_idx = '0;
        has_free = 1'b0; free_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            match[i] = valid_reg[i] && (ip_reg[i] == addr_reg);
        end
        for (int i = ENTRIES-1; i >= 0; i--) begin
            if (match[i]) begin
                hit = 1'b1; hit_idx = IDX_W'(i);
            end
            if (!valid_reg[i]) begin
                has_free = 1'b1; free_idx = IDX_W'(i);
            end
        end
        wr_idx = hit ? hit_idx : (has_free ? free_idx : old_idx);
    end

    logic [STAMP_W-1:0] tick_inc;
    assign tick_inc = tick_reg + STAMP_W'(1);

    assign sts_o.is_lookup = (op_reg == CMD_LOOKUP);
    assign sts_o.do_learn  = learn_reg;

    // Control state: table entries (valid, IP, MAC, stamp), tick, result flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            tick_reg  <= STAMP_W'(1);
            ok_reg    <= 1'b0;
            reply_reg <= 1'b0;
            learn_reg <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                ip_reg[i]    <= '0;
                mac_reg[i]   <= '0;
                stamp_reg[i] <= '0;
            end
        end else begin
            if (cmd_i.load) begin
                ok_reg    <= 1'b0;
                reply_reg <= 1'b0;
                learn_reg <= 1'b0;
                if (enable_i) begin
                    case (s_cmd)
                        CMD_REQUEST: begin
                            if (s_hw_addr != '0 && s_hw_addr != MAC_BCAST) begin
                                ok_reg    <= 1'b1;
                                reply_reg <= (s_target_addr == own_ip_i);
                                learn_reg <= (s_address != '0);
                            end
                        end
                        CMD_REPLY: begin
                            if (s_target_addr == own_ip_i && s_address != '0 &&
                                s_hw_addr != '0 && s_hw_addr != MAC_BCAST) begin
                                ok_reg    <= 1'b1;
                                learn_reg <= 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // Tick advance with wrap and expiry
            if (cmd_i.age) begin
                if (tick_inc == '0) begin
                    tick_reg <= STAMP_W'(1);
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (valid_reg[i]) stamp_reg[i] <= STAMP_W'(1);
                    end
                end else begin
                    tick_reg <= tick_inc;
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (valid_reg[i] &&
                            (tick_inc - stamp_reg[i]) > {16'd0, max_age_i}) begin
                            valid_reg[i] <= 1'b0;
                            ip_reg[i]    <= '0;
                            mac_reg[i]   <= '0;
                            stamp_reg[i] <= '0;
                        end
                    end
                end
            end
            // Lookup: refresh hit
            if (cmd_i.search) begin
                ok_reg <= hit;
                if (hit) stamp_reg[hit_idx] <= tick_reg;
            end
            // Learn write
            if (cmd_i.learn) begin
                valid_reg[wr_idx] <= 1'b1;
                ip_reg[wr_idx]    <= addr_reg;
                mac_reg[wr_idx]   <= hw_reg;
                stamp_reg[wr_idx] <= tick_reg;
            end
        end
    end

    // Payload capture and found-MAC result register
    always_ff @(posedge aclk) begin
        if (cmd_i.load) begin
            op_reg       <= enable_i ? s_cmd : CMD_NONE;
            addr_reg     <= s_address;
            hw_reg       <= s_hw_addr;
            fmac_reg     <= '0;
        end
        if (cmd_i.search) fmac_reg <= hit ? mac_reg[hit_idx] : '0;
    end

    assign res_ok_o    = ok_reg;
    assign res_mac_o   = fmac_reg;
    assign res_reply_o = reply_reg;
endmodule

### rtl/arp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_ctrl
// Sequencer: accept, then age and search (lookup) or learn, then present result.
// ----------------------------------------------------------------------------
module arp_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output arp_pkg::arp_cmd_t cmd_o,
    input  arp_pkg::arp_sts_t sts_i
);
    import arp_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_AGE    = 5'b00010,
        ST_SEARCH = 5'b00100,
        ST_LEARN  = 5'b01000,
        ST_OUT    = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);

    always_comb begin
        state_next   = state_reg;
        cmd_o        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_o.load = 1'b1;
                    state_next = ST_AGE;
                end
            end
            ST_AGE: begin
                if (sts_i.is_lookup) begin
                    cmd_o.age  = 1'b1;
                    state_next = ST_SEARCH;
                end else if (sts_i.do_learn) begin
                    state_next = ST_LEARN;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_SEARCH: begin
                cmd_o.search = 1'b1;
                state_next   = ST_OUT;
            end
            ST_LEARN: begin
                cmd_o.learn = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end
endmodule

### rtl/arp_cache_resolver_core.sv
`timescale 1ns / 1ps
// Sequencing: after acceptance each transaction enters the age state; a lookup then
// goes through search, a learn through learn, anything else straight to result. The
// sequencer handles one transaction at a time; all entries are compared in parallel.
// Reset: synchronous active-low aresetn clears the whole cache, tick to 1,
// enable=0, own IP=0, max_age=300.
// ----------------------------------------------------------------------------
// arp_cache_resolver_core
// ARP cache with aging: APB registers, controller and datapath.
// ----------------------------------------------------------------------------
module arp_cache_resolver_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [arp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_cmd,
    input  logic [31:0]                s_address,
    input  logic [47:0]                s_hw_addr,
    input  logic [31:0]                s_target_addr,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_ok,
    output logic [47:0]                m_found_mac,
    output logic                       m_send_reply
);
    import arp_pkg::*;

    logic             enable_reg;
    logic [31:0]      own_ip_reg;
    logic [AGE_W-1:0] max_age_reg;
    arp_cmd_t         cmd;
    arp_sts_t         sts;

    assign pready = 1'b1;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg  <= 1'b0;
            own_ip_reg  <= '0;
            max_age_reg <= MAX_AGE_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr)
                REG_ENABLE:  enable_reg  <= pwdata[0];
                REG_OWN_IP:  own_ip_reg  <= pwdata;
                REG_MAX_AGE: max_age_reg <= pwdata[AGE_W-1:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (paddr)
            REG_ENABLE:  prdata = {31'd0, enable_reg};
            REG_OWN_IP:  prdata = own_ip_reg;
            REG_MAX_AGE: prdata = {16'd0, max_age_reg};
            default:     prdata = '0;
        endcase
    end

    arp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd_o   (cmd),
        .sts_i   (sts)
    );

    arp_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_i         (cmd),
        .sts_o         (sts),
        .enable_i      (enable_reg),
        .own_ip_i      (own_ip_reg),
        .max_age_i     (max_age_reg),
        .s_cmd         (s_cmd),
        .s_address     (s_address),
        .s_hw_addr     (s_hw_addr),
        .s_target_addr (s_target_addr),
        .res_ok_o      (m_ok),
        .res_mac_o     (m_found_mac),
        .res_reply_o   (m_send_reply)
    );
endmodule

### tb/sv/arp_cache_resolver_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_cache_resolver_core_tb
// Self-checking bench for the ARP cache: drives lookups, requests and replies
// through valid/ready, programs the registers over APB between phases, and
// checks every result against an in-bench cache and aging model or a fixed value.
// ----------------------------------------------------------------------------
module arp_cache_resolver_core_tb;
    import arp_pkg::*;

    localparam logic [1:0]        CMD_UNUSED = 2'd3;
    localparam logic [ADDR_W-1:0] REG_UNUSED = 4'hC;
    localparam logic [MAC_W-1:0]  MAC_ZERO   = '0;
    localparam int                POOL_SZ    = 24;

    typedef struct {
        logic [1:0]       cmd;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
        logic [IP_W-1:0]  tgt;
        bit               fixed;
        logic             ok;
        logic [MAC_W-1:0] found;
        logic             reply;
    } arp_row_t;

    typedef struct packed {
        logic             ok;
        logic [MAC_W-1:0] found;
        logic             reply;
    } arp_res_t;

    logic             aclk = 0;
    logic             aresetn = 0;
    logic             psel = 0, penable = 0, pwrite = 0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]      pwdata = '0;
    logic [31:0]      prdata;
    logic             pready;
    logic             s_valid = 0;
    logic             s_ready;
    logic [1:0]       s_cmd = '0;
    logic [31:0]      s_address = '0;
    logic [47:0]      s_hw_addr = '0;
    logic [31:0]      s_target_addr = '0;
    logic             m_valid;
    logic             m_ready = 0;
    logic             m_ok;
    logic [47:0]      m_found_mac;
    logic             m_send_reply;

    arp_cache_resolver_core uut (.*);

    always #5 aclk = ~aclk;

    // Model of the cache
    bit               c_valid [ENTRIES];
    bit [IP_W-1:0]    c_ip    [ENTRIES];
    bit [MAC_W-1:0]   c_mac   [ENTRIES];
    bit [STAMP_W-1:0] c_stamp [ENTRIES];
    bit [STAMP_W-1:0] c_tick = 1;
    bit               c_enable = 0;
    bit [IP_W-1:0]    c_own_ip = 0;
    bit [AGE_W-1:0]   c_max_age = MAX_AGE_RST;

    arp_res_t   pending_q[$];
    arp_row_t   dir_q[$];
    logic [31:0] ip_pool [POOL_SZ];
    int         errors = 0;
    int         accepted = 0;
    int         s_idle = 0, r_idle = 0;

    function automatic bit mac_usable(logic [MAC_W-1:0] mac);
        return mac != MAC_ZERO && mac != MAC_BCAST;
    endfunction

    function automatic int find_ip(logic [IP_W-1:0] ip);
        for (int i = 0; i < ENTRIES; i++)
            if (c_valid[i] && c_ip[i] == ip) return i;
        return -1;
    endfunction

    function automatic bit learn_mapping(logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac);
        int idx;
        if (ip == 0 || !mac_usable(mac)) return 0;
        idx = find_ip(ip);
        if (idx < 0)
            for (int i = 0; i < ENTRIES; i++)
                if (!c_valid[i]) begin
                    idx = i;
                    break;
                end
        // Table full: evict oldest stamp, lowest index on ties
        if (idx < 0) begin
            idx = 0;
            for (int i = 1; i < ENTRIES; i++)
                if (c_stamp[i] < c_stamp[idx]) idx = i;
        end
        c_valid[idx] = 1;
        c_ip[idx]    = ip;
        c_mac[idx]   = mac;
        c_stamp[idx] = c_tick;
        return 1;
    endfunction

    function automatic arp_res_t resolve(logic [1:0] cmd, logic [IP_W-1:0] ip,
                                         logic [MAC_W-1:0] mac, logic [IP_W-1:0] tgt);
        arp_res_t r;
        int idx;
        r = '0;
        if (!c_enable) return r;
        case (cmd)
            CMD_LOOKUP: begin
                c_tick = c_tick + 1;
                if (c_tick == 0) begin
                    c_tick = 1;
                    for (int i = 0; i < ENTRIES; i++)
                        if (c_valid[i]) c_stamp[i] = 1;
                end
                // Expire stale entries
                for (int i = 0; i < ENTRIES; i++)
                    if (c_valid[i] && (c_tick - c_stamp[i]) > {16'd0, c_max_age}) begin
                        c_valid[i] = 0;
                        c_ip[i] = 0;
                        c_mac[i] = 0;
                        c_stamp[i] = 0;
                    end
                idx = find_ip(ip);
                if (idx >= 0) begin
                    r.ok = 1;
                    r.found = c_mac[idx];
                    c_stamp[idx] = c_tick;
                end
            end
            CMD_REQUEST: begin
                if (mac_usable(mac)) begin
                    void'(learn_mapping(ip, mac));
                    r.ok = 1;
                    r.reply = (tgt == c_own_ip);
                end
            end
            CMD_REPLY: begin
                if (tgt == c_own_ip && mac_usable(mac) && learn_mapping(ip, mac))
                    r.ok = 1;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic arp_row_t row(logic [1:0] cmd, logic [31:0] ip, logic [47:0] mac,
                                     logic [31:0] tgt, bit fixed = 0);
        arp_row_t t;
        t.cmd = cmd; t.ip = ip; t.mac = mac; t.tgt = tgt; t.fixed = fixed;
        t.ok = 0; t.found = '0; t.reply = 0;
        return t;
    endfunction

    // APB write: setup and access phases, then idle before returning
    task automatic reg_write(logic [ADDR_W-1:0] addr, logic [31:0] data);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (addr)
            REG_ENABLE:  c_enable  = data[0];
            REG_OWN_IP:  c_own_ip  = data;
            REG_MAX_AGE: c_max_age = data[AGE_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Wait until the block has drained before touching registers
    task automatic drain;
        s_valid <= 0;
        @(posedge aclk);
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic configure(bit en, logic [31:0] lip, logic [15:0] age);
        drain();
        reg_write(REG_ENABLE, {31'd0, en});
        reg_write(REG_OWN_IP, lip);
        reg_write(REG_MAX_AGE, {16'd0, age});
    endtask

    // Offer one transaction; valid stays high into the next call
    task automatic send(arp_row_t t);
        arp_res_t r;
        while ($urandom_range(99) < s_idle) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1; s_cmd <= t.cmd; s_address <= t.ip;
        s_hw_addr <= t.mac; s_target_addr <= t.tgt;
        do @(posedge aclk); while (!s_ready);
        r = resolve(t.cmd, t.ip, t.mac, t.tgt);
        if (t.fixed) r = '{ok: t.ok, found: t.found, reply: t.reply};
        pending_q.push_back(r);
        accepted++;
    endtask

    function automatic arp_row_t random_item;
        arp_row_t t;
        int sel;
        t = row('0, '0, '0, '0);
        sel = $urandom_range(99);
        t.cmd = sel < 45 ? CMD_LOOKUP : sel < 70 ? CMD_REQUEST : sel < 95 ? CMD_REPLY
                                                                        : CMD_UNUSED;
        sel = $urandom_range(99);
        t.ip = sel < 85 ? ip_pool[$urandom_range(POOL_SZ-1)] : sel < 95 ? $urandom : '0;
        sel = $urandom_range(99);
        t.mac = sel < 90 ? 48'({$urandom, $urandom}) : sel < 95 ? MAC_ZERO : MAC_BCAST;
        sel = $urandom_range(99);
        t.tgt = sel < 50 ? c_own_ip : sel < 90 ? ip_pool[$urandom_range(POOL_SZ-1)]
                                               : $urandom;
        return t;
    endfunction

    task automatic random_phase(int n);
        repeat (n) send(random_item());
    endtask

    // Result side: random stalls plus one long hold-off to back up the input
    int  hold_left = 0;
    bit  held = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 0;
        end else if (!held && accepted >= 400) begin
            held <= 1;
            hold_left <= 300;
            m_ready <= 0;
        end else begin
            m_ready <= ($urandom_range(99) >= r_idle);
        end
    end

    // Result check
    always @(posedge aclk) begin
        arp_res_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("ERROR: unexpected result ok=%0b mac=%h reply=%0b",
                                           m_ok, m_found_mac, m_send_reply);
            end else begin
                e = pending_q.pop_front();
                if (m_ok !== e.ok || m_found_mac !== e.found || m_send_reply !== e.reply) begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: exp ok=%0b mac=%h reply=%0b got ok=%0b mac=%h reply=%0b",
                                 e.ok, e.found, e.reply, m_ok, m_found_mac, m_send_reply);
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    localparam logic [31:0] LIP = 32'h0A00_0001;

    initial begin
        for (int i = 0; i < POOL_SZ; i++) ip_pool[i] = $urandom | 32'h1;
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed part; disabled after reset, every item fails
        dir_q.push_back(row(CMD_LOOKUP, 32'h0A00_0002, '0, '0, 1));
        dir_q.push_back(row(CMD_REQUEST, 32'h0A00_0002, 48'h0011_2233_4455, '0, 1));
        dir_q.push_back(row(CMD_REPLY, 32'h0A00_0002, 48'h0011_2233_4455, '0, 1));
        foreach (dir_q[i]) send(dir_q[i]);
        dir_q.delete();

        configure(1, LIP, 16'd4);
        reg_write(REG_UNUSED, 32'hFFFF_FFFF);
        dir_q.push_back(row(CMD_LOOKUP, 32'h0A00_0002, '0, '0));
        dir_q.push_back(row(CMD_REQUEST, 32'h0A00_0002, 48'h0011_2233_4455, LIP));
        dir_q.push_back(row(CMD_LOOKUP, 32'h0A00_0002, '0, '0));
        dir_q.push_back(row(CMD_REQUEST, 32'h0A00_0005, MAC_ZERO, LIP, 1));
        dir_q.push_back(row(CMD_REQUEST, 32'h0A00_0005, MAC_BCAST, LIP, 1));
        dir_q.push_back(row(CMD_REPLY, 32'h0A00_0005, MAC_BCAST, LIP, 1));
        dir_q.push_back(row(CMD_REPLY, 32'h0, 48'h0000_0000_0001, LIP, 1));
        dir_q.push_back(row(CMD_REQUEST, 32'h0, 48'h0000_0000_0001, LIP));
        dir_q.push_back(row(CMD_REPLY, 32'h0A00_0006, 48'h0000_0000_0001, 32'h0A00_0009, 1));
        dir_q.push_back(row(CMD_REPLY, 32'hFFFF_FFFF, 48'h0000_0000_0001, LIP));
        dir_q.push_back(row(CMD_UNUSED, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFE, LIP, 1));
        dir_q.push_back(row(CMD_REQUEST, 32'h0A00_0003, 48'hFFFF_FFFF_FFFE, 32'hFFFF_FFFF));
        dir_q.push_back(row(CMD_LOOKUP, 32'hFFFF_FFFF, '1, '1));
        for (int i = 0; i < 6; i++) dir_q.push_back(row(CMD_LOOKUP, 32'h0101_0101, '0, '0));
        dir_q.push_back(row(CMD_LOOKUP, 32'h0A00_0003, '0, '0));
        dir_q.push_back(row(CMD_REPLY, 32'h0A00_0002, 48'h8000_0000_0000, LIP));
        dir_q.push_back(row(CMD_LOOKUP, 32'h0A00_0002, '0, '0));
        foreach (dir_q[i]) send(dir_q[i]);

        // Random part under three idle patterns and several register settings
        s_idle = 13; r_idle = 66;
        configure(1, LIP, MAX_AGE_RST);
        random_phase(300);
        configure(1, 32'h0, 16'd1);
        random_phase(250);
        s_idle = 66; r_idle = 13;
        configure(1, 32'hFFFF_FFFF, 16'hFFFF);
        random_phase(300);
        configure(0, $urandom, 16'd20);
        random_phase(50);
        s_idle = 0; r_idle = 0;
        configure(1, ip_pool[0], 16'($urandom_range(2, 40)));
        random_phase(400);
        configure(1, ip_pool[1], 16'($urandom_range(41, 2000)));
        random_phase(400);

        drain();
        repeat (10) @(posedge aclk);
        if (errors == 0 && pending_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### arp_cache_resolver_core.f
rtl/arp_pkg.sv
rtl/arp_datapath.sv
rtl/arp_ctrl.sv
rtl/arp_cache_resolver_core.sv
tb/sv/arp_cache_resolver_core_tb.sv
